// ===== rtl/q2rm_pkg.sv =====
// Package: widths, word types and latency for the quaternion to rotation matrix block.
`timescale 1ns / 1ps
`default_nettype none
package q2rm_pkg;
  localparam int IN_W   = 16;            // quaternion component width
  localparam int FRAC   = 14;            // output fraction bits
  localparam int OUT_W  = FRAC + 2;      // output entry width
  localparam int PROD_W = 2 * IN_W;      // one product
  localparam int NORM_W = 2 * IN_W + 1;  // squared norm, unsigned
  localparam int NUM_W  = NORM_W + 1;    // signed numerator
  localparam int QUO_W  = FRAC + 2;      // raw quotient incl. round bit
  localparam int LANES  = 9;
  localparam int STEPS  = FRAC + 1;
  localparam int LATENCY = STEPS + 4;

  typedef struct packed {
    logic signed [IN_W-1:0] q_scalar;
    logic signed [IN_W-1:0] q_x;
    logic signed [IN_W-1:0] q_y;
    logic signed [IN_W-1:0] q_z;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic                    norm_error;
  } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix_top.sv =====
// Top level: pipelined quaternion to rotation matrix conversion.
`timescale 1ns / 1ps
`default_nettype none
// Takes one quaternion word per clock (start while busy is low) and returns
// its 3x3 rotation matrix as Q1.14 entries, saturated to +/-1.0, on rot,
// marked by a one-cycle done strobe. The receiver cannot stall: every
// result is shown for one cycle only. busy is high only during reset, so
// the sustained rate is one word per cycle. The pipeline is: one stage of
// ten 16x16 products, one stage forming the squared norm and nine
// numerators, one stage taking magnitudes and the integer quotient bit,
// fifteen restoring-division stages (one quotient bit each, nine lanes
// sharing the norm as divisor), and one stage of rounding (half away from
// zero), clamping and sign restore. The division stages give one per
// fraction bit plus one for the round bit. An all-zero quaternion gives a
// zero matrix with norm_error set.
module quaternion_to_rotation_matrix_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire q2rm_pkg::in_word_t quat,
  output q2rm_pkg::out_word_t     rot,
  output logic                    done
);
  localparam int NW = q2rm_pkg::NORM_W;
  localparam int MW = q2rm_pkg::NUM_W;
  localparam int PW = q2rm_pkg::PROD_W;
  localparam int QW = q2rm_pkg::QUO_W;
  localparam int OW = q2rm_pkg::OUT_W;
  localparam int L  = q2rm_pkg::LANES;
  localparam int S  = q2rm_pkg::STEPS;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // stage A: products ss xx yy zz xy sz xz sy yz sx
  logic signed [PW-1:0] prod [10];
  logic                 va;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= accept;
    prod[0] <= quat.q_scalar * quat.q_scalar;
    prod[1] <= quat.q_x * quat.q_x;
    prod[2] <= quat.q_y * quat.q_y;
    prod[3] <= quat.q_z * quat.q_z;
    prod[4] <= quat.q_x * quat.q_y;
    prod[5] <= quat.q_scalar * quat.q_z;
    prod[6] <= quat.q_x * quat.q_z;
    prod[7] <= quat.q_scalar * quat.q_y;
    prod[8] <= quat.q_y * quat.q_z;
    prod[9] <= quat.q_scalar * quat.q_x;
  end

  function automatic logic signed [MW-1:0] sx(input logic signed [PW-1:0] p);
    sx = MW'(p);
  endfunction

  // stage B: norm and numerators
  logic signed [MW-1:0] num [L];
  logic        [NW-1:0] nb;
  logic                 vb;
  logic signed [MW-1:0] ss, xx, yy, zz, nsum;
  always_comb begin
    ss = sx(prod[0]); xx = sx(prod[1]); yy = sx(prod[2]); zz = sx(prod[3]);
    nsum = ss + xx + yy + zz;
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
    nb     <= nsum[NW-1:0];
    num[0] <= ss + xx - yy - zz;
    num[1] <= (sx(prod[4]) - sx(prod[5])) <<< 1;
    num[2] <= (sx(prod[6]) + sx(prod[7])) <<< 1;
    num[3] <= (sx(prod[4]) + sx(prod[5])) <<< 1;
    num[4] <= ss + yy - xx - zz;
    num[5] <= (sx(prod[8]) - sx(prod[9])) <<< 1;
    num[6] <= (sx(prod[6]) - sx(prod[7])) <<< 1;
    num[7] <= (sx(prod[8]) + sx(prod[9])) <<< 1;
    num[8] <= ss + zz - xx - yy;
  end

  // division pipeline, index 0 filled by stage C
  logic [NW-1:0] rem  [S+1][L];
  logic [QW-1:0] quo  [S+1][L];
  logic          neg  [S+1][L];
  logic          sat  [S+1][L];
  logic [NW-1:0] den  [S+1];
  logic          zero [S+1];
  logic          vd   [S+1];

  // stage C: magnitude, integer bit, overflow check
  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else     vd[0] <= vb;
    den[0]  <= nb;
    zero[0] <= (nb == '0);
  end
  for (genvar k = 0; k < L; k++) begin : g_pre
    logic [MW-1:0] mag;
    logic          ge1, ge2;
    always_comb begin
      mag = num[k][MW-1] ? MW'(-num[k]) : MW'(num[k]);
      ge1 = mag >= {1'b0, nb};
      ge2 = {1'b0, mag} >= {1'b0, nb, 1'b0};
    end
    always_ff @(posedge clk) begin
      neg[0][k] <= num[k][MW-1];
      sat[0][k] <= ge2;
      rem[0][k] <= ge1 ? NW'(mag - {1'b0, nb}) : mag[NW-1:0];
      quo[0][k] <= ge1 ? QW'(1) : '0;
    end
  end

  // restoring steps, one quotient bit per stage
  for (genvar j = 0; j < S; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vd[j+1] <= 1'b0;
      else     vd[j+1] <= vd[j];
      den[j+1]  <= den[j];
      zero[j+1] <= zero[j];
    end
    for (genvar k = 0; k < L; k++) begin : g_lane
      logic [NW:0] r2;
      logic        take;
      always_comb begin
        r2   = {rem[j][k], 1'b0};
        take = r2 >= {1'b0, den[j]};
      end
      always_ff @(posedge clk) begin
        neg[j+1][k] <= neg[j][k];
        sat[j+1][k] <= sat[j][k];
        rem[j+1][k] <= take ? NW'(r2 - {1'b0, den[j]}) : r2[NW-1:0];
        quo[j+1][k] <= {quo[j][k][QW-2:0], take};
      end
    end
  end

  // output stage: round, clamp, sign
  localparam logic [QW:0] LIMIT = (QW+1)'(1) << q2rm_pkg::FRAC;
  logic [OW-1:0] ent [L];
  for (genvar k = 0; k < L; k++) begin : g_out
    logic [QW:0] rnd;
    logic [QW:0] mg;
    always_comb begin
      rnd = ({1'b0, quo[S][k]} + (QW+1)'(1)) >> 1;
      mg  = (sat[S][k] || rnd > LIMIT) ? LIMIT : rnd;
      if (zero[S])        ent[k] = '0;
      else if (neg[S][k]) ent[k] = OW'(-mg);
      else                ent[k] = OW'(mg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd[S];
    rot.r00 <= ent[0]; rot.r01 <= ent[1]; rot.r02 <= ent[2];
    rot.r10 <= ent[3]; rot.r11 <= ent[4]; rot.r12 <= ent[5];
    rot.r20 <= ent[6]; rot.r21 <= ent[7]; rot.r22 <= ent[8];
    rot.norm_error <= zero[S];
  end

`ifndef SYNTHESIS
  // every accepted word comes out on done after q2rm_pkg::LATENCY
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(q2rm_pkg::LATENCY) done)
    else $error("result strobe missing at pipeline latency");
  // a zero quaternion (norm_error) gives a zero diagonal
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rot.norm_error) |-> (rot.r00 == '0 && rot.r11 == '0 && rot.r22 == '0))
    else $error("error word with nonzero diagonal");
  // entries r00 and r12 never pass +/-1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rot.r00 <= 16'sd16384 && rot.r00 >= -16'sd16384
              && rot.r12 <= 16'sd16384 && rot.r12 >= -16'sd16384))
    else $error("entry outside saturation range");
`endif
endmodule
`default_nettype wire
